### hw/rtl/srsp_pkg.sv
// ----------------------------------------------------------------------------
// srsp_pkg
// Types, codes and helper functions shared by the scene record stream parser.
// ----------------------------------------------------------------------------
package srsp_pkg;

  localparam int unsigned COLOR_ENTRIES = 256;
  localparam int unsigned CIDX_W        = $clog2(COLOR_ENTRIES);
  localparam logic [31:0] MAGIC_WORD    = 32'hDEADBEEF;
  localparam int unsigned FIFO_DEPTH    = 8;
  localparam int unsigned FPTR_W        = $clog2(FIFO_DEPTH);

  localparam logic [3:0] SEC_HEADER  = 4'd0;
  localparam logic [3:0] SEC_COLORS  = 4'd1;
  localparam logic [3:0] SEC_TILES   = 4'd2;
  localparam logic [3:0] SEC_SCREENS = 4'd3;
  localparam logic [3:0] SEC_GLYPHS  = 4'd5;
  localparam logic [3:0] SEC_FONTS   = 4'd6;
  localparam logic [3:0] SEC_TEXTS   = 4'd7;
  localparam logic [3:0] SEC_BUNDLES = 4'd8;

  localparam logic [4:0] FID_COUNT    = 5'd0;
  localparam logic [4:0] FID_MAGIC    = 5'd1;
  localparam logic [4:0] FID_LENGTH   = 5'd2;
  localparam logic [4:0] FID_T_LEFT   = 5'd5;
  localparam logic [4:0] FID_T_TOP    = 5'd6;
  localparam logic [4:0] FID_T_WIDTH  = 5'd7;
  localparam logic [4:0] FID_T_RIGHT  = 5'd8;
  localparam logic [4:0] FID_T_HEIGHT = 5'd9;
  localparam logic [4:0] FID_T_BOTTOM = 5'd10;
  localparam logic [4:0] FID_T_VIS    = 5'd11;
  localparam logic [4:0] FID_T_COLOR  = 5'd12;
  localparam logic [4:0] FID_T_RGBA   = 5'd13;
  localparam logic [4:0] FID_T_TYPE   = 5'd14;
  localparam logic [4:0] FID_T_TEXB   = 5'd15;
  localparam logic [4:0] FID_T_STRIPE = 5'd16;
  localparam logic [4:0] FID_T_COMP   = 5'd17;
  localparam logic [4:0] FID_G_TEXB   = 5'd7;
  localparam logic [4:0] FID_G_COMP   = 5'd9;
  localparam logic [4:0] FID_X_CHARS  = 5'd1;
  localparam logic [4:0] FID_X_HALIGN = 5'd6;
  localparam logic [4:0] FID_X_VALIGN = 5'd7;
  localparam logic [4:0] FID_X_CHAR   = 5'd8;
  localparam logic [4:0] FID_TEXT_LEN = 5'd31;

  typedef enum logic [2:0] {
    ST_FIELD     = 3'd0,
    ST_DONE      = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_BAD_TYPE  = 3'd4,
    ST_BAD_COMP  = 3'd5
  } status_e;

  typedef struct packed {
    logic [3:0]  section;
    logic [15:0] record_index;
    logic [4:0]  field_id;
    logic [31:0] field_value;
    logic [2:0]  status;
    logic        last;
  } res_t;

  // bytes in the field at this grammar step
  function automatic logic [2:0] field_bytes(input logic [3:0] sec, input logic [4:0] st);
    logic [2:0] n;
    n = 3'd2;
    if (sec == SEC_HEADER) begin
      n = 3'd4;
    end else if (st == FID_COUNT || st == FID_TEXT_LEN) begin
      n = 3'd2;
    end else begin
      unique case (sec)
        SEC_TILES: begin
          if (st == FID_T_VIS || st == FID_T_TYPE || st == FID_T_COMP) n = 3'd1;
          else if (st == FID_T_TEXB) n = 3'd4;
        end
        SEC_GLYPHS: begin
          if (st == FID_G_TEXB) n = 3'd4;
          else if (st == FID_G_COMP) n = 3'd1;
        end
        SEC_TEXTS: begin
          if (st == FID_X_HALIGN || st == FID_X_VALIGN) n = 3'd1;
        end
        SEC_BUNDLES: n = 3'd4;
        default: n = 3'd2;
      endcase
    end
    return n;
  endfunction

  // step after a finished field inside a record, zero ends the record
  function automatic logic [4:0] next_step(input logic [3:0] sec, input logic [4:0] st,
                                           input logic tex, input logic chr_any,
                                           input logic chr_more);
    logic [4:0] n;
    n = 5'd0;
    unique case (sec)
      SEC_TILES: begin
        if (st <= FID_T_TOP) n = st + 5'd1;
        else if (st == FID_T_WIDTH) n = FID_T_HEIGHT;
        else if (st == FID_T_HEIGHT) n = FID_T_VIS;
        else if (st == FID_T_VIS) n = FID_T_COLOR;
        else if (st == FID_T_COLOR) n = FID_T_TYPE;
        else if (st == FID_T_TYPE) n = tex ? FID_T_TEXB : 5'd0;
        else if (st == FID_T_TEXB || st == FID_T_STRIPE) n = st + 5'd1;
      end
      SEC_SCREENS, SEC_BUNDLES: n = (st == 5'd1) ? 5'd2 : 5'd0;
      SEC_GLYPHS: n = (st < 5'd9) ? st + 5'd1 : 5'd0;
      SEC_FONTS:  n = (st < 5'd3) ? st + 5'd1 : 5'd0;
      SEC_TEXTS: begin
        if (st < FID_X_VALIGN) n = st + 5'd1;
        else if (st == FID_X_VALIGN) n = chr_any ? FID_X_CHAR : 5'd0;
        else n = chr_more ? FID_X_CHAR : 5'd0;
      end
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // nibble times 17 is the nibble repeated
  function automatic logic [31:0] rgba_of(input logic [15:0] c);
    return {c[15:12], c[15:12], c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
  endfunction

endpackage

### hw/rtl/srsp_stream_if.sv
// ----------------------------------------------------------------------------
// srsp stream interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;
  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface srsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  section;
  logic [15:0] record_index;
  logic [4:0]  field_id;
  logic [31:0] field_value;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, output section, output record_index, output field_id,
                  output field_value, output status, output last, input ready);
  modport sink   (input valid, input section, input record_index, input field_id,
                  input field_value, input status, input last, output ready);
endinterface

### hw/rtl/srsp_res_fifo.sv
// ----------------------------------------------------------------------------
// srsp_res_fifo
// Result queue: takes up to three results a cycle, hands out one a cycle when popped.
// ----------------------------------------------------------------------------
module srsp_res_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            push_n_i,
  input  srsp_pkg::res_t        push_data_i [3],
  input  logic                  pop_i,
  output srsp_pkg::res_t        head_o,
  output logic [srsp_pkg::FPTR_W:0] count_o
);
  import srsp_pkg::*;

  res_t              mem_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wptr_q, rptr_q;
  logic [FPTR_W:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n_i) mem_q[wptr_q + FPTR_W'(i)] <= push_data_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + FPTR_W'(push_n_i);
      if (pop_i) rptr_q <= rptr_q + FPTR_W'(1);
      cnt_q  <= cnt_q + (FPTR_W+1)'(push_n_i) - (FPTR_W+1)'(pop_i);
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign count_o = cnt_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FPTR_W+1)'(FIFO_DEPTH)) else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0) else $error("pop from empty result queue");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i == 2'd0 && !pop_i) |=> $stable(cnt_q)) else $error("count drift");

endmodule

### hw/rtl/scene_record_stream_parser_top.sv
// ----------------------------------------------------------------------------
// scene_record_stream_parser_top
// Parses a scene image byte by byte and emits field, derived and status results.
// ----------------------------------------------------------------------------
// One byte is taken per cycle. The grammar state, the color table read and the
// packed results are registered at the accepting edge; the results then queue
// in an eight-entry buffer that drains one per cycle while the sink is ready.
// A byte makes at most three results, so input stalls only when the result side
// is slow or a run of bytes makes more than one result each. The color table is
// a RAM of COLOR_ENTRIES words with one write port and one registered read port;
// a lookup beyond the stored colors gives zero, so unwritten entries never show.
module scene_record_stream_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  srsp_in_if.sink     in_i,
  srsp_out_if.source  out_o
);
  import srsp_pkg::*;

  logic [31:0] pos_q, dlen_q, acc_q;
  logic [3:0]  sec_q;
  logic [4:0]  step_q;
  logic [1:0]  bif_q;
  logic [15:0] rcnt_q, rtot_q, ccnt_q, ctot_q, edge0_q, edge1_q, ccount_q;
  logic        tex_q, fin_q;

  logic [31:0] pos_d, dlen_d, acc_d;
  logic [3:0]  sec_d;
  logic [4:0]  step_d;
  logic [1:0]  bif_d;
  logic [15:0] rcnt_d, rtot_d, ccnt_d, ctot_d, edge0_d, edge1_d, ccount_d;
  logic        tex_d, fin_d;

  logic [31:0] pos_e, dlen_e, acc_e, acc_v, ov;
  logic [3:0]  sec_e;
  logic [4:0]  step_e, nx;
  logic [1:0]  bif_e;
  logic [15:0] rcnt_e, rtot_e, ccnt_e, ctot_e, edge0_e, edge1_e, ccount_e;
  logic        tex_e, fin_e, do_end, bad;

  logic        f_en, x_en, x_rgba, cok, cwr;
  logic [4:0]  f_id, x_id;
  logic [31:0] f_val, x_val;
  status_e     stop;
  res_t        slot [3];
  logic [1:0]  n_res;

  logic              accept;
  logic              s_vld_q, s_xrgba_q, s_cok_q;
  logic [1:0]        s_n_q;
  res_t              s_slot_q [3];
  res_t              push_data [3];
  logic [1:0]        push_n;
  logic [15:0]       color_mem [COLOR_ENTRIES];
  logic [15:0]       rd_q;
  logic [FPTR_W:0]   fcnt;
  res_t              head;

  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    pos_e    = in_i.start_req ? '0 : pos_q;
    dlen_e   = in_i.start_req ? '0 : dlen_q;
    acc_e    = in_i.start_req ? '0 : acc_q;
    sec_e    = in_i.start_req ? SEC_HEADER : sec_q;
    step_e   = in_i.start_req ? '0 : step_q;
    bif_e    = in_i.start_req ? '0 : bif_q;
    rcnt_e   = in_i.start_req ? '0 : rcnt_q;
    rtot_e   = in_i.start_req ? '0 : rtot_q;
    ccnt_e   = in_i.start_req ? '0 : ccnt_q;
    ctot_e   = in_i.start_req ? '0 : ctot_q;
    edge0_e  = in_i.start_req ? '0 : edge0_q;
    edge1_e  = in_i.start_req ? '0 : edge1_q;
    ccount_e = in_i.start_req ? '0 : ccount_q;
    tex_e    = in_i.start_req ? 1'b0 : tex_q;
    fin_e    = in_i.start_req ? 1'b0 : fin_q;

    pos_d = pos_e;  dlen_d = dlen_e;  acc_d = acc_e;  sec_d = sec_e;  step_d = step_e;
    bif_d = bif_e;  rcnt_d = rcnt_e;  rtot_d = rtot_e;  ccnt_d = ccnt_e;  ctot_d = ctot_e;
    edge0_d = edge0_e;  edge1_d = edge1_e;  ccount_d = ccount_e;  tex_d = tex_e;
    fin_d = fin_e;
    f_en = 1'b0;  f_id = '0;  f_val = '0;  x_en = 1'b0;  x_id = '0;  x_val = '0;
    x_rgba = 1'b0;  stop = ST_FIELD;  do_end = 1'b0;  bad = 1'b0;  cwr = 1'b0;  nx = '0;
    ov = '0;

    acc_v = (bif_e == 2'd0) ? {24'd0, in_i.data_byte}
                            : acc_e | ({24'd0, in_i.data_byte} << {bif_e, 3'b000});
    cok = ({1'b0, acc_v[15:0]} < {1'b0, ccount_e}) &&
          ({1'b0, acc_v[15:0]} < 17'(COLOR_ENTRIES));

    if (!fin_e) begin
      pos_d = pos_e + 32'd1;
      acc_d = acc_v;
      if ({1'b0, bif_e} + 3'd1 < field_bytes(sec_e, step_e)) begin
        bif_d = bif_e + 2'd1;
      end else begin
        bif_d = 2'd0;
        if (sec_e == SEC_HEADER) begin
          if (step_e == FID_COUNT) begin
            if (acc_v != MAGIC_WORD) begin
              stop  = ST_BAD_MAGIC;
              fin_d = 1'b1;
            end else begin
              f_en = 1'b1;  f_id = FID_MAGIC;  f_val = acc_v;  step_d = 5'd1;
            end
          end else begin
            dlen_d = acc_v;
            f_en = 1'b1;  f_id = FID_LENGTH;  f_val = acc_v;
            sec_d = SEC_COLORS;  step_d = '0;
          end
        end else if (step_e == FID_TEXT_LEN) begin
          f_en = 1'b1;  f_id = FID_TEXT_LEN;  f_val = acc_v;  step_d = '0;
        end else if (step_e == FID_COUNT) begin
          f_en = 1'b1;  f_id = FID_COUNT;  f_val = acc_v;
          rtot_d = acc_v[15:0];
          rcnt_d = '0;
          if (acc_v == '0) do_end = 1'b1;
          else step_d = 5'd1;
        end else begin
          ov = acc_v;
          if (sec_e == SEC_COLORS) begin
            if ({1'b0, rcnt_e} < 17'(COLOR_ENTRIES)) begin
              cwr      = 1'b1;
              ccount_d = rcnt_e + 16'd1;
            end
          end else if (sec_e == SEC_TILES) begin
            if (step_e == FID_T_LEFT) edge0_d = acc_v[15:0];
            else if (step_e == FID_T_TOP) edge1_d = acc_v[15:0];
            else if (step_e == FID_T_WIDTH) begin
              x_en = 1'b1;  x_id = FID_T_RIGHT;
              x_val = {16'd0, edge0_e + acc_v[15:0] - 16'd1};
            end else if (step_e == FID_T_HEIGHT) begin
              x_en = 1'b1;  x_id = FID_T_BOTTOM;
              x_val = {16'd0, edge1_e + acc_v[15:0] - 16'd1};
            end else if (step_e == FID_T_VIS) begin
              ov = {31'd0, acc_v == 32'd1};
            end else if (step_e == FID_T_COLOR) begin
              x_en = 1'b1;  x_id = FID_T_RGBA;  x_rgba = 1'b1;
            end else if (step_e == FID_T_TYPE) begin
              if (acc_v >= 32'd2) begin
                bad = 1'b1;  stop = ST_BAD_TYPE;
              end else begin
                tex_d = (acc_v == 32'd1);
              end
            end else if (step_e == FID_T_COMP && acc_v >= 32'd2) begin
              bad = 1'b1;  stop = ST_BAD_COMP;
            end
          end else if (sec_e == SEC_GLYPHS) begin
            if (step_e == FID_G_COMP && acc_v >= 32'd2) begin
              bad = 1'b1;  stop = ST_BAD_COMP;
            end
          end else if (sec_e == SEC_TEXTS) begin
            if (step_e == FID_X_CHARS) ctot_d = acc_v[15:0];
            else if (step_e == FID_X_HALIGN || step_e == FID_X_VALIGN)
              ov = (acc_v == 32'd1 || acc_v == 32'd2) ? acc_v : '0;
            if (step_e == FID_X_VALIGN) ccnt_d = '0;
            else if (step_e == FID_X_CHAR) ccnt_d = ccnt_e + 16'd1;
          end

          if (bad) begin
            fin_d = 1'b1;
          end else begin
            f_en = 1'b1;  f_id = step_e;  f_val = ov;
            nx = next_step(sec_e, step_e, tex_d, ctot_d != '0, ccnt_d < ctot_d);
            if (nx != '0) begin
              step_d = nx;
            end else begin
              rcnt_d = rcnt_e + 16'd1;
              if (rcnt_d == rtot_e) do_end = 1'b1;
              else step_d = 5'd1;
            end
          end
        end

        if (do_end) begin
          rcnt_d = '0;
          rtot_d = '0;
          if (sec_e >= SEC_BUNDLES) begin
            fin_d = 1'b1;
            stop  = ST_DONE;
          end else begin
            sec_d  = sec_e + 4'd1;
            step_d = (sec_d == SEC_TEXTS) ? FID_TEXT_LEN : FID_COUNT;
          end
        end
      end

      // declared length reached before the grammar finished
      if (!fin_d && pos_e >= 32'd7 && ({1'b0, pos_e} + 33'd1 >= {1'b0, dlen_d})) begin
        fin_d = 1'b1;
        stop  = ST_TRUNC;
      end
    end

    for (int i = 0; i < 3; i++) slot[i] = '0;
    n_res = 2'd0;
    if (f_en) begin
      slot[0] = '{section: sec_e, record_index: (f_id == FID_COUNT || sec_e == SEC_HEADER ||
                  f_id == FID_TEXT_LEN) ? 16'd0 : rcnt_e,
                  field_id: f_id, field_value: f_val, status: ST_FIELD, last: 1'b0};
      n_res = 2'd1;
    end
    if (x_en) begin
      slot[1] = '{section: sec_e, record_index: rcnt_e, field_id: x_id,
                  field_value: x_val, status: ST_FIELD, last: 1'b0};
      n_res = 2'd2;
    end
    if (stop != ST_FIELD) begin
      slot[n_res] = '{section: sec_d, record_index: 16'd0, field_id: 5'd0,
                      field_value: pos_e, status: stop, last: 1'b0};
      n_res = n_res + 2'd1;
    end
  end

  // color table and registered read for the tile color lookup
  always_ff @(posedge clk_i) begin
    if (accept && cwr) color_mem[rcnt_e[CIDX_W-1:0]] <= acc_v[15:0];
    if (accept) rd_q <= color_mem[acc_v[CIDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_slot_q  <= slot;
      s_n_q     <= n_res;
      s_xrgba_q <= x_rgba;
      s_cok_q   <= cok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;  dlen_q <= '0;  acc_q <= '0;  sec_q <= SEC_HEADER;  step_q <= '0;
      bif_q <= '0;  rcnt_q <= '0;  rtot_q <= '0;  ccnt_q <= '0;  ctot_q <= '0;
      edge0_q <= '0;  edge1_q <= '0;  ccount_q <= '0;  tex_q <= 1'b0;  fin_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= accept && (n_res != 2'd0);
      if (accept) begin
        pos_q <= pos_d;  dlen_q <= dlen_d;  acc_q <= acc_d;  sec_q <= sec_d;
        step_q <= step_d;  bif_q <= bif_d;  rcnt_q <= rcnt_d;  rtot_q <= rtot_d;
        ccnt_q <= ccnt_d;  ctot_q <= ctot_d;  edge0_q <= edge0_d;  edge1_q <= edge1_d;
        ccount_q <= ccount_d;  tex_q <= tex_d;  fin_q <= fin_d;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_data[i]      = s_slot_q[i];
      push_data[i].last = (2'(i) + 2'd1 == s_n_q);
    end
    if (s_xrgba_q) push_data[1].field_value = s_cok_q ? rgba_of(rd_q) : '0;
    push_n = s_vld_q ? s_n_q : 2'd0;
  end

  srsp_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data_i (push_data),
    .pop_i       (out_o.valid && out_o.ready),
    .head_o      (head),
    .count_o     (fcnt)
  );

  // room for the results in flight plus a worst-case byte
  assign in_i.ready = ((FPTR_W+2)'(fcnt) + (FPTR_W+2)'(push_n)) <=
                      (FPTR_W+2)'(FIFO_DEPTH - 3);

  assign out_o.valid        = (fcnt != '0);
  assign out_o.section      = head.section;
  assign out_o.record_index = head.record_index;
  assign out_o.field_id     = head.field_id;
  assign out_o.field_value  = head.field_value;
  assign out_o.status       = head.status;
  assign out_o.last         = head.last;

  a_stage_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_vld_q |-> s_n_q != 2'd0) else $error("empty result stage marked valid");
  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fin_q && !in_i.start_req) |=> !s_vld_q)
    else $error("results after parse stop");
  a_field_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && bif_d != 2'd0) |-> n_res == 2'd0 || stop == ST_TRUNC)
    else $error("field result mid-field");

endmodule
